### hw/rtl/ple_pkg.sv
// ple_pkg: shared types and constants for the positional list engine.
// Holds the controller states, datapath micro-ops, command codes and status struct.
// No dependencies.
`default_nettype none

package ple_pkg;

    // Storage size and derived widths
    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int PW       = (LEN_W > 6) ? LEN_W : 6;
    localparam int AMT_W    = 16;
    localparam int CNT_W    = $clog2(AMT_W);
    localparam int DATA_W   = 32;

    // Command codes
    localparam logic [2:0] CMD_INSERT  = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_DUMP    = 3'd2;
    localparam logic [2:0] CMD_MOVE    = 3'd3;
    localparam logic [2:0] CMD_REVERSE = 3'd4;
    localparam logic [2:0] CMD_ROT_L   = 3'd5;
    localparam logic [2:0] CMD_ROT_R   = 3'd6;

    // Controller states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INS_INIT,
        ST_INS_CHK,
        ST_INS_RD,
        ST_INS_WR,
        ST_INS_PUT,
        ST_DEL_INIT,
        ST_DEL_CHK,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_DEL_DONE,
        ST_MV_RD,
        ST_MV_CAP,
        ST_DUMP_INIT,
        ST_DUMP_RD,
        ST_DUMP_EMIT,
        ST_DUMP_EMPTY,
        ST_MOD,
        ST_ROT_CHK,
        ST_KSET,
        ST_RV_SET,
        ST_RV_CHK,
        ST_RV_RD1,
        ST_RV_RD2,
        ST_RV_W1,
        ST_RV_W2
    } t_state;

    // Datapath micro-ops, one per cycle
    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_LOAD,
        UOP_INS_INIT,
        UOP_INS_RD,
        UOP_INS_WR,
        UOP_INS_PUT,
        UOP_DEL_INIT,
        UOP_DEL_RD,
        UOP_DEL_WR,
        UOP_DEL_DONE,
        UOP_MV_RD,
        UOP_MV_CAP,
        UOP_DUMP_INIT,
        UOP_DUMP_RD,
        UOP_DUMP_EMIT,
        UOP_DUMP_EMPTY,
        UOP_MOD_STEP,
        UOP_KSET_L,
        UOP_KSET_R,
        UOP_RV_SET0K,
        UOP_RV_SETKL,
        UOP_RV_SET0L,
        UOP_RV_RD1,
        UOP_RV_RD2,
        UOP_RV_W1,
        UOP_RV_W2
    } t_uop;

    // Datapath status back to the controller
    typedef struct packed {
        logic [2:0] cmd;
        logic       ins_ok;
        logic       del_ok;
        logic       mv_ok;
        logic       len_zero;
        logic       ins_more;
        logic       del_more;
        logic       dump_last;
        logic       rv_more;
        logic       mod_last;
        logic       rem_zero;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/positional_list_engine.sv
// Positional list engine: ordered store of up to CAPACITY signed words.
// Insert and remove shift the store one moved element at a time (check, read, write), dump
// reads and emits each element in turn, reverse swaps pairs (check, read both, write both),
// rotate runs 16 remainder steps plus three reverses, and move is a remove then an insert.
// One item at a time, bounded by the single-read/single-write element memory.
// Sync active-low reset clears length and control; the receiver cannot stall.
`default_nettype none

module positional_list_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         i_command,
    input  wire logic signed [31:0] i_value,
    input  wire logic [5:0]         i_pos_a,
    input  wire logic [5:0]         i_pos_b,
    input  wire logic [15:0]        i_amount,
    output logic                    o_valid,
    output logic signed [31:0]      o_element,
    output logic                    o_last,
    output logic                    o_empty_res
);

    ple_pkg::t_uop    uop;
    ple_pkg::t_status status;

    // Sequencer
    ple_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_uop    (uop),
        .busy     (busy)
    );

    // Storage and arithmetic
    ple_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uop       (uop),
        .i_command   (i_command),
        .i_value     (i_value),
        .i_pos_a     (i_pos_a),
        .i_pos_b     (i_pos_b),
        .i_amount    (i_amount),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_element   (o_element),
        .o_last      (o_last),
        .o_empty_res (o_empty_res)
    );

endmodule

`default_nettype wire

### hw/rtl/ple_dp.sv
// ple_dp: datapath of the positional list engine: element memory, length,
// walk pointers, remainder unit and registered result port. Uses ple_pkg.
`default_nettype none

module ple_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ple_pkg::t_uop                i_uop,
    input  wire logic [2:0]                   i_command,
    input  wire logic signed [31:0]           i_value,
    input  wire logic [5:0]                   i_pos_a,
    input  wire logic [5:0]                   i_pos_b,
    input  wire logic [15:0]                  i_amount,
    output ple_pkg::t_status                  o_status,
    output logic                              o_valid,
    output logic signed [31:0]                o_element,
    output logic                              o_last,
    output logic                              o_empty_res
);

    localparam int PW = ple_pkg::PW;
    localparam int AW = ple_pkg::ADDR_W;
    localparam int DW = ple_pkg::DATA_W;

    // Element store
    logic [DW-1:0] mem [ple_pkg::CAPACITY];

    logic [2:0]                  r_cmd;
    logic [DW-1:0]               r_val, r_tmp, r_rdata;
    logic [PW-1:0]               r_pa, r_pb, r_ip, r_len, r_idx, r_lo, r_hi, r_k;
    logic [ple_pkg::AMT_W-1:0]   r_amt;
    logic [PW:0]                 r_rem;
    logic [ple_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_ov, r_olast, r_oempty;
    logic [DW-1:0]               r_oelem;

    logic [AW-1:0] raddr, waddr;
    logic [DW-1:0] wdata;
    logic          we;
    logic [PW:0]   rem_sh;
    logic [PW-1:0] hi_m1;

    assign hi_m1  = r_hi - PW'(1);
    assign rem_sh = {r_rem[PW-1:0], r_amt[ple_pkg::AMT_W-1]};

    // Memory address and data selection
    always_comb begin
        raddr = r_idx[AW-1:0];
        waddr = r_idx[AW-1:0];
        wdata = r_rdata;
        we    = 1'b0;
        case (i_uop)
            ple_pkg::UOP_INS_RD:  raddr = AW'(r_idx - PW'(1));
            ple_pkg::UOP_DEL_RD:  raddr = AW'(r_idx + PW'(1));
            ple_pkg::UOP_MV_RD:   raddr = r_pa[AW-1:0];
            ple_pkg::UOP_DUMP_RD: raddr = r_idx[AW-1:0];
            ple_pkg::UOP_RV_RD1:  raddr = r_lo[AW-1:0];
            ple_pkg::UOP_RV_RD2:  raddr = hi_m1[AW-1:0];
            ple_pkg::UOP_INS_WR:  we = 1'b1;
            ple_pkg::UOP_DEL_WR:  we = 1'b1;
            ple_pkg::UOP_INS_PUT: begin
                we    = 1'b1;
                waddr = r_ip[AW-1:0];
                wdata = r_val;
            end
            ple_pkg::UOP_RV_W1: begin
                we    = 1'b1;
                waddr = r_lo[AW-1:0];
            end
            ple_pkg::UOP_RV_W2: begin
                we    = 1'b1;
                waddr = hi_m1[AW-1:0];
                wdata = r_tmp;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            case (i_uop)
                ple_pkg::UOP_INS_PUT:  r_len <= r_len + PW'(1);
                ple_pkg::UOP_DEL_DONE: r_len <= r_len - PW'(1);
                default: ;
            endcase
        end
        case (i_uop)
            ple_pkg::UOP_LOAD: begin
                r_cmd <= i_command;
                r_val <= DW'(i_value);
                r_pa  <= PW'(i_pos_a);
                r_pb  <= PW'(i_pos_b);
                r_ip  <= PW'(i_pos_a);
                r_amt <= i_amount;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ple_pkg::UOP_INS_INIT:  r_idx <= r_len;
            ple_pkg::UOP_INS_WR:    r_idx <= r_idx - PW'(1);
            ple_pkg::UOP_DEL_INIT:  r_idx <= r_pa;
            ple_pkg::UOP_DEL_WR:    r_idx <= r_idx + PW'(1);
            ple_pkg::UOP_MV_CAP: begin
                r_val <= r_rdata;
                r_ip  <= r_pb;
            end
            ple_pkg::UOP_DUMP_INIT: r_idx <= '0;
            ple_pkg::UOP_DUMP_EMIT: r_idx <= r_idx + PW'(1);
            ple_pkg::UOP_MOD_STEP: begin
                r_rem <= (rem_sh >= {1'b0, r_len}) ? rem_sh - {1'b0, r_len} : rem_sh;
                r_amt <= r_amt << 1;
                r_cnt <= r_cnt + ple_pkg::CNT_W'(1);
            end
            ple_pkg::UOP_KSET_L:    r_k <= r_rem[PW-1:0];
            ple_pkg::UOP_KSET_R:    r_k <= r_len - r_rem[PW-1:0];
            ple_pkg::UOP_RV_SET0K: begin
                r_lo <= '0;
                r_hi <= r_k;
            end
            ple_pkg::UOP_RV_SETKL: begin
                r_lo <= r_k;
                r_hi <= r_len;
            end
            ple_pkg::UOP_RV_SET0L: begin
                r_lo <= '0;
                r_hi <= r_len;
            end
            ple_pkg::UOP_RV_RD2:    r_tmp <= r_rdata;
            ple_pkg::UOP_RV_W2: begin
                r_lo <= r_lo + PW'(1);
                r_hi <= hi_m1;
            end
            default: ;
        endcase
    end

    // Result register: one-cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= (i_uop == ple_pkg::UOP_DUMP_EMIT) || (i_uop == ple_pkg::UOP_DUMP_EMPTY);
        end
        if (i_uop == ple_pkg::UOP_DUMP_EMPTY) begin
            r_oelem  <= '0;
            r_olast  <= 1'b1;
            r_oempty <= 1'b1;
        end else begin
            r_oelem  <= r_rdata;
            r_olast  <= (r_idx + PW'(1)) == r_len;
            r_oempty <= 1'b0;
        end
    end

    assign o_valid     = r_ov;
    assign o_element   = signed'(r_oelem);
    assign o_last      = r_olast;
    assign o_empty_res = r_oempty;

    // Status
    always_comb begin
        o_status.cmd       = r_cmd;
        o_status.ins_ok    = (r_len < PW'(ple_pkg::CAPACITY)) && (r_pa <= r_len);
        o_status.del_ok    = r_pa < r_len;
        o_status.mv_ok     = (r_pa < r_len) && (r_pb < r_len);
        o_status.len_zero  = r_len == '0;
        o_status.ins_more  = r_idx > r_ip;
        o_status.del_more  = (r_idx + PW'(1)) < r_len;
        o_status.dump_last = (r_idx + PW'(1)) == r_len;
        o_status.rv_more   = (r_lo + PW'(1)) < r_hi;
        o_status.mod_last  = r_cnt == ple_pkg::CNT_W'(ple_pkg::AMT_W - 1);
        o_status.rem_zero  = r_rem == '0;
    end

endmodule

`default_nettype wire

### hw/rtl/ple_ctrl.sv
// ple_ctrl: controller state machine of the positional list engine.
// Issues one datapath micro-op per cycle from state and status. Uses ple_pkg.
`default_nettype none

module ple_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire ple_pkg::t_status  i_status,
    output ple_pkg::t_uop          o_uop,
    output logic                   busy
);

    ple_pkg::t_state r_state, n_state;
    logic [1:0]      r_phase, n_phase;
    logic            r_mv, n_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ple_pkg::ST_IDLE;
            r_phase <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_mv    <= n_mv;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_mv    = r_mv;
        case (r_state)
            ple_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = ple_pkg::ST_DECODE;
                    n_mv    = 1'b0;
                end
            end
            ple_pkg::ST_DECODE: begin
                case (i_status.cmd)
                    ple_pkg::CMD_INSERT:
                        n_state = i_status.ins_ok ? ple_pkg::ST_INS_INIT : ple_pkg::ST_IDLE;
                    ple_pkg::CMD_REMOVE:
                        n_state = i_status.del_ok ? ple_pkg::ST_DEL_INIT : ple_pkg::ST_IDLE;
                    ple_pkg::CMD_MOVE:
                        n_state = i_status.mv_ok ? ple_pkg::ST_MV_RD : ple_pkg::ST_IDLE;
                    ple_pkg::CMD_DUMP:
                        n_state = i_status.len_zero ? ple_pkg::ST_DUMP_EMPTY
                                                    : ple_pkg::ST_DUMP_INIT;
                    ple_pkg::CMD_REVERSE: begin
                        n_state = ple_pkg::ST_RV_SET;
                        n_phase = 2'd2;
                    end
                    ple_pkg::CMD_ROT_L, ple_pkg::CMD_ROT_R:
                        n_state = i_status.len_zero ? ple_pkg::ST_IDLE : ple_pkg::ST_MOD;
                    default: n_state = ple_pkg::ST_IDLE;
                endcase
            end
            ple_pkg::ST_INS_INIT: n_state = ple_pkg::ST_INS_CHK;
            ple_pkg::ST_INS_CHK:
                n_state = i_status.ins_more ? ple_pkg::ST_INS_RD : ple_pkg::ST_INS_PUT;
            ple_pkg::ST_INS_RD:   n_state = ple_pkg::ST_INS_WR;
            ple_pkg::ST_INS_WR:   n_state = ple_pkg::ST_INS_CHK;
            ple_pkg::ST_INS_PUT:  n_state = ple_pkg::ST_IDLE;
            ple_pkg::ST_DEL_INIT: n_state = ple_pkg::ST_DEL_CHK;
            ple_pkg::ST_DEL_CHK:
                n_state = i_status.del_more ? ple_pkg::ST_DEL_RD : ple_pkg::ST_DEL_DONE;
            ple_pkg::ST_DEL_RD:   n_state = ple_pkg::ST_DEL_WR;
            ple_pkg::ST_DEL_WR:   n_state = ple_pkg::ST_DEL_CHK;
            ple_pkg::ST_DEL_DONE:
                n_state = r_mv ? ple_pkg::ST_INS_INIT : ple_pkg::ST_IDLE;
            ple_pkg::ST_MV_RD:    n_state = ple_pkg::ST_MV_CAP;
            ple_pkg::ST_MV_CAP: begin
                n_state = ple_pkg::ST_DEL_INIT;
                n_mv    = 1'b1;
            end
            ple_pkg::ST_DUMP_INIT: n_state = ple_pkg::ST_DUMP_RD;
            ple_pkg::ST_DUMP_RD:   n_state = ple_pkg::ST_DUMP_EMIT;
            ple_pkg::ST_DUMP_EMIT:
                n_state = i_status.dump_last ? ple_pkg::ST_IDLE : ple_pkg::ST_DUMP_RD;
            ple_pkg::ST_DUMP_EMPTY: n_state = ple_pkg::ST_IDLE;
            ple_pkg::ST_MOD:
                if (i_status.mod_last) begin
                    n_state = ple_pkg::ST_ROT_CHK;
                end
            ple_pkg::ST_ROT_CHK:
                n_state = i_status.rem_zero ? ple_pkg::ST_IDLE : ple_pkg::ST_KSET;
            ple_pkg::ST_KSET: begin
                n_state = ple_pkg::ST_RV_SET;
                n_phase = 2'd0;
            end
            ple_pkg::ST_RV_SET:   n_state = ple_pkg::ST_RV_CHK;
            ple_pkg::ST_RV_CHK: begin
                if (i_status.rv_more) begin
                    n_state = ple_pkg::ST_RV_RD1;
                end else if (r_phase == 2'd2) begin
                    n_state = ple_pkg::ST_IDLE;
                end else begin
                    n_state = ple_pkg::ST_RV_SET;
                    n_phase = r_phase + 2'd1;
                end
            end
            ple_pkg::ST_RV_RD1:   n_state = ple_pkg::ST_RV_RD2;
            ple_pkg::ST_RV_RD2:   n_state = ple_pkg::ST_RV_W1;
            ple_pkg::ST_RV_W1:    n_state = ple_pkg::ST_RV_W2;
            ple_pkg::ST_RV_W2:    n_state = ple_pkg::ST_RV_CHK;
            default:              n_state = ple_pkg::ST_IDLE;
        endcase
    end

    // Micro-op outputs
    always_comb begin
        o_uop = ple_pkg::UOP_NONE;
        case (r_state)
            ple_pkg::ST_IDLE:
                if (start) begin
                    o_uop = ple_pkg::UOP_LOAD;
                end
            ple_pkg::ST_INS_INIT:   o_uop = ple_pkg::UOP_INS_INIT;
            ple_pkg::ST_INS_RD:     o_uop = ple_pkg::UOP_INS_RD;
            ple_pkg::ST_INS_WR:     o_uop = ple_pkg::UOP_INS_WR;
            ple_pkg::ST_INS_PUT:    o_uop = ple_pkg::UOP_INS_PUT;
            ple_pkg::ST_DEL_INIT:   o_uop = ple_pkg::UOP_DEL_INIT;
            ple_pkg::ST_DEL_RD:     o_uop = ple_pkg::UOP_DEL_RD;
            ple_pkg::ST_DEL_WR:     o_uop = ple_pkg::UOP_DEL_WR;
            ple_pkg::ST_DEL_DONE:   o_uop = ple_pkg::UOP_DEL_DONE;
            ple_pkg::ST_MV_RD:      o_uop = ple_pkg::UOP_MV_RD;
            ple_pkg::ST_MV_CAP:     o_uop = ple_pkg::UOP_MV_CAP;
            ple_pkg::ST_DUMP_INIT:  o_uop = ple_pkg::UOP_DUMP_INIT;
            ple_pkg::ST_DUMP_RD:    o_uop = ple_pkg::UOP_DUMP_RD;
            ple_pkg::ST_DUMP_EMIT:  o_uop = ple_pkg::UOP_DUMP_EMIT;
            ple_pkg::ST_DUMP_EMPTY: o_uop = ple_pkg::UOP_DUMP_EMPTY;
            ple_pkg::ST_MOD:        o_uop = ple_pkg::UOP_MOD_STEP;
            ple_pkg::ST_KSET:
                o_uop = (i_status.cmd == ple_pkg::CMD_ROT_R) ? ple_pkg::UOP_KSET_R
                                                             : ple_pkg::UOP_KSET_L;
            ple_pkg::ST_RV_SET: begin
                case (r_phase)
                    2'd0:    o_uop = ple_pkg::UOP_RV_SET0K;
                    2'd1:    o_uop = ple_pkg::UOP_RV_SETKL;
                    default: o_uop = ple_pkg::UOP_RV_SET0L;
                endcase
            end
            ple_pkg::ST_RV_RD1:     o_uop = ple_pkg::UOP_RV_RD1;
            ple_pkg::ST_RV_RD2:     o_uop = ple_pkg::UOP_RV_RD2;
            ple_pkg::ST_RV_W1:      o_uop = ple_pkg::UOP_RV_W1;
            ple_pkg::ST_RV_W2:      o_uop = ple_pkg::UOP_RV_W2;
            default:                o_uop = ple_pkg::UOP_NONE;
        endcase
    end

    assign busy = r_state != ple_pkg::ST_IDLE;

endmodule

`default_nettype wire
